// ----- src/jpea_pkg.sv -----
package jpea_pkg;

  // Per-joint store depth
  localparam int unsigned NUM_JOINTS = 32;
  localparam int unsigned JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Field widths
  localparam int unsigned FOCAL_W  = 18;
  localparam int unsigned CENTER_W = 16;
  localparam int unsigned THR_W    = 20;
  localparam int unsigned CFG_W    = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned DEPTH_W  = 18;
  localparam int unsigned DIST_W   = 24;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned COUNT_W  = 32;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned OUT_USER_W = 2;

  // Iterative unit sizing
  localparam int unsigned WORK_W     = 50;  // dividend / radicand shift register
  localparam int unsigned REM_W      = 28;  // partial remainder
  localparam int unsigned ROOT_W     = 25;
  localparam int unsigned MAG_W      = 25;  // clamped component magnitude
  localparam int unsigned COMP_W     = 40;  // signed back-projected coordinate
  localparam int unsigned QUOT_W     = 39;
  localparam int unsigned DIV_STEPS  = 39;
  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned STEP_W     = 6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 3'd4;

  // Register reset values
  localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 18'd150536;
  localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 18'd150290;
  localparam logic [CENTER_W-1:0] CENTER_X_RST = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST = 16'd3840;
  localparam logic [THR_W-1:0]    THR_RST      = 20'd320;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [MAG_W-1:0]   MAG_CLAMP = 25'h100_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_DIFF,
    ST_SQ,
    ST_ACC,
    ST_SQRT,
    ST_UPD
  } state_e;

endpackage

// ----- src/jpea_ram.sv -----
module jpea_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/joint_pose_error_accumulator.sv -----
// Joint pose error accumulator. Each input transaction carries one joint: a
// predicted and a labelled pixel position with depth. Both are back-projected
// through the pinhole camera set by the focal and center registers, and the
// truncated integer 3D distance between them (1/16 mm) is returned together
// with the running distance total and the joint's seen and detected counts.
// A label whose three fields sum to zero is skipped and changes nothing. All
// totals saturate; clear_totals (tuser) wipes them before its own joint.
// A skipped joint goes straight from setup to the result register; a valid one
// first runs the back-projections and the square root. The block accepts the
// next joint only once the result is registered. The result waits while an
// earlier result still sits unaccepted in the output register.
// One 28-bit compare-subtract unit runs the four back-projection divisions
// (39 steps each) and the square root (25 steps), one bit or bit pair per
// cycle. A finished result waits in the output register while the next joint
// is accepted. Configuration must be written only while no joint is in flight;
// the block itself does not enforce this.
module joint_pose_error_accumulator
  import jpea_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: joint_index[4:0], pred_u[20:5], pred_v[36:21], pred_depth[54:37],
  //        label_u[70:55], label_v[86:71], label_depth[104:87], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: clear_totals[0]
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: joint_distance[23:0], total_distance[71:24], joint_seen[103:72],
  //        joint_detected[135:104]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: joint_valid[0], joint_hit[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  // Configuration registers
  logic [FOCAL_W-1:0]  focal_x_q, focal_y_q;
  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [THR_W-1:0]    thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_X_RST;
      focal_y_q  <= FOCAL_Y_RST;
      center_x_q <= CENTER_X_RST;
      center_y_q <= CENTER_Y_RST;
      thr_q      <= THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FOCAL_X:       focal_x_q  <= cfg_wdata_i[FOCAL_W-1:0];
        REG_FOCAL_Y:       focal_y_q  <= cfg_wdata_i[FOCAL_W-1:0];
        REG_CENTER_X:      center_x_q <= cfg_wdata_i[CENTER_W-1:0];
        REG_CENTER_Y:      center_y_q <= cfg_wdata_i[CENTER_W-1:0];
        REG_HIT_THRESHOLD: thr_q      <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and control
  state_e                state_q, state_d;
  logic [STEP_W-1:0]     step_q;
  logic [1:0]            idx_q;
  logic                  out_valid_q;
  logic                  s_accept, commit, out_free;

  // Latched joint
  logic [4:0]            jidx_q;
  logic signed [PIX_W-1:0] pu_q, pv_q, lu_q, lv_q;
  logic [DEPTH_W-1:0]    pd_q, ld_q;
  logic                  valid_q;

  // Iterative unit state
  logic [WORK_W-1:0]     work_q;
  logic [REM_W-1:0]      rem_q;
  logic [ROOT_W-1:0]     root_q;
  logic [FOCAL_W-1:0]    den_q;
  logic                  neg_q;
  logic signed [COMP_W-1:0] comp_q [4];
  logic [MAG_W-1:0]      mag_q [3];
  logic [2*MAG_W-1:0]    prod_q;
  logic [WORK_W-1:0]     sum_q;

  // Accumulated totals
  logic [TOTAL_W-1:0]    total_q;
  logic [NUM_JOINTS-1:0] entry_valid_q;

  // Output register
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [OUT_USER_W-1:0] out_user_q;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign commit   = (state_q == ST_UPD) && out_free;

  // Label presence: the three label fields must not sum to zero
  logic signed [19:0] label_sum;
  assign label_sum = 20'(lu_q) + 20'(lv_q) + $signed({2'b00, ld_q});

  // Next state and handshake
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = (label_sum != '0) ? ST_MUL : ST_UPD;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = (idx_q == 2'd3) ? ST_DIFF : ST_MUL;
        end
      end
      ST_DIFF:  state_d = ST_SQ;
      ST_SQ:    state_d = ST_ACC;
      ST_ACC:   state_d = (idx_q == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT: begin
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Back-projection operand select for division idx_q
  logic signed [PIX_W-1:0]  bp_pix;
  logic [CENTER_W-1:0]      bp_ctr;
  logic [DEPTH_W-1:0]       bp_depth;
  logic [FOCAL_W-1:0]       bp_focal;
  logic signed [17:0]       bp_diff;
  logic [17:0]              bp_neg;
  logic [16:0]              bp_mag;

  always_comb begin
    case (idx_q)
      2'd0: begin bp_pix = pu_q; bp_ctr = center_x_q; bp_depth = pd_q; bp_focal = focal_x_q; end
      2'd1: begin bp_pix = pv_q; bp_ctr = center_y_q; bp_depth = pd_q; bp_focal = focal_y_q; end
      2'd2: begin bp_pix = lu_q; bp_ctr = center_x_q; bp_depth = ld_q; bp_focal = focal_x_q; end
      default: begin
        bp_pix = lv_q; bp_ctr = center_y_q; bp_depth = ld_q; bp_focal = focal_y_q;
      end
    endcase
  end

  assign bp_diff = 18'(bp_pix) - $signed({2'b00, bp_ctr});
  assign bp_neg  = 18'(-bp_diff);
  assign bp_mag  = bp_diff[17] ? bp_neg[16:0] : bp_diff[16:0];

  // Shared multiplier: magnitude times depth, or a component square
  logic [MAG_W-1:0]   mul_a, mul_b;
  logic [2*MAG_W-1:0] mul_p;

  always_comb begin
    if (state_q == ST_SQ) begin
      mul_a = mag_q[idx_q];
      mul_b = mag_q[idx_q];
    end else begin
      mul_a = MAG_W'(bp_mag);
      mul_b = MAG_W'(bp_depth);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Shared compare-subtract unit: one division bit or one root bit per cycle
  logic [REM_W-1:0] unit_cand, unit_trial, unit_rem;
  logic [REM_W:0]   unit_sub;
  logic             unit_ge;

  always_comb begin
    if (state_q == ST_SQRT) begin
      unit_cand  = {rem_q[REM_W-3:0], work_q[WORK_W-1 -: 2]};
      unit_trial = REM_W'({root_q, 2'b01});
    end else begin
      unit_cand  = {rem_q[REM_W-2:0], work_q[WORK_W-1]};
      unit_trial = REM_W'(den_q);
    end
  end

  assign unit_sub = {1'b0, unit_cand} - {1'b0, unit_trial};
  assign unit_ge  = !unit_sub[REM_W];
  assign unit_rem = unit_ge ? unit_sub[REM_W-1:0] : unit_cand;

  // Final quotient of the running division, with sign restored
  logic [QUOT_W-1:0]        quot;
  logic signed [COMP_W-1:0] quot_pos, quot_signed;

  assign quot        = {work_q[QUOT_W-2:0], unit_ge};
  assign quot_pos    = $signed({1'b0, quot});
  assign quot_signed = neg_q ? -quot_pos : quot_pos;

  // Component differences, absolute and clamped
  logic signed [COMP_W:0] dx, dy;
  logic [COMP_W:0]        ax, ay;
  logic signed [DEPTH_W:0] dz;
  logic [DEPTH_W:0]       az;

  assign dx = (COMP_W+1)'(comp_q[0]) - (COMP_W+1)'(comp_q[2]);
  assign dy = (COMP_W+1)'(comp_q[1]) - (COMP_W+1)'(comp_q[3]);
  assign dz = $signed({1'b0, pd_q}) - $signed({1'b0, ld_q});
  assign ax = dx[COMP_W] ? (COMP_W+1)'(-dx) : dx;
  assign ay = dy[COMP_W] ? (COMP_W+1)'(-dy) : dy;
  assign az = dz[DEPTH_W] ? (DEPTH_W+1)'(-dz) : dz;

  function automatic logic [MAG_W-1:0] clamp_mag(input logic [COMP_W:0] v);
    if (v >= (COMP_W+1)'(MAG_CLAMP)) begin
      return MAG_CLAMP;
    end
    return v[MAG_W-1:0];
  endfunction

  // Result and update values
  logic [JIDX_W-1:0]    ram_addr;
  logic [8:0]           jidx_ext;
  logic                 in_range;
  logic [2*COUNT_W-1:0] ram_rdata, ram_wdata;
  logic [COUNT_W-1:0]   seen_cur, hit_cur, seen_new, hit_new;
  logic [DIST_W-1:0]    dist_val;
  logic                 hit;
  logic [TOTAL_W:0]     total_sum;
  logic [TOTAL_W-1:0]   total_new;

  assign jidx_ext = 9'(jidx_q);
  assign ram_addr = jidx_ext[JIDX_W-1:0];
  assign in_range = jidx_ext < 9'(NUM_JOINTS);

  always_comb begin
    if (in_range && entry_valid_q[ram_addr]) begin
      seen_cur = ram_rdata[COUNT_W-1:0];
      hit_cur  = ram_rdata[2*COUNT_W-1:COUNT_W];
    end else begin
      seen_cur = '0;
      hit_cur  = '0;
    end
    if (!valid_q) begin
      dist_val = '0;
    end else if (root_q[ROOT_W-1]) begin
      dist_val = DIST_MAX;
    end else begin
      dist_val = root_q[DIST_W-1:0];
    end
    hit       = valid_q && (dist_val <= DIST_W'(thr_q));
    total_sum = {1'b0, total_q} + (TOTAL_W+1)'(dist_val);
    total_new = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    seen_new  = seen_cur;
    hit_new   = hit_cur;
    if (valid_q && seen_cur != COUNT_MAX) begin
      seen_new = seen_cur + 1'b1;
    end
    if (hit && hit_cur != COUNT_MAX) begin
      hit_new = hit_cur + 1'b1;
    end
  end

  assign ram_wdata = {hit_new, seen_new};

  jpea_ram #(
    .WIDTH (2 * COUNT_W),
    .DEPTH (NUM_JOINTS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (commit && valid_q && in_range),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // Control counters, totals and entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q        <= '0;
      idx_q         <= '0;
      total_q       <= '0;
      entry_valid_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_accept && s_axis_tuser) begin
            total_q       <= '0;
            entry_valid_q <= '0;
          end
        end
        ST_SETUP: idx_q  <= '0;
        ST_MUL:   step_q <= '0;
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DIFF: idx_q <= '0;
        ST_ACC: begin
          idx_q  <= idx_q + 1'b1;
          step_q <= '0;
        end
        ST_SQRT: step_q <= step_q + 1'b1;
        ST_UPD: begin
          if (commit && valid_q) begin
            total_q <= total_new;
            if (in_range) begin
              entry_valid_q[ram_addr] <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          jidx_q <= s_axis_tdata[4:0];
          pu_q   <= s_axis_tdata[20:5];
          pv_q   <= s_axis_tdata[36:21];
          pd_q   <= s_axis_tdata[54:37];
          lu_q   <= s_axis_tdata[70:55];
          lv_q   <= s_axis_tdata[86:71];
          ld_q   <= s_axis_tdata[104:87];
        end
      end
      ST_SETUP: valid_q <= (label_sum != '0);
      ST_MUL: begin
        // Load dividend (mag * depth * 16) left-aligned in the work register
        work_q <= {mul_p[34:0], 4'b0000, 11'b0};
        rem_q  <= '0;
        den_q  <= (bp_focal == '0) ? FOCAL_W'(1) : bp_focal;
        neg_q  <= bp_diff[17];
      end
      ST_DIV: begin
        rem_q  <= unit_rem;
        work_q <= {work_q[WORK_W-2:0], unit_ge};
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          comp_q[idx_q] <= quot_signed;
        end
      end
      ST_DIFF: begin
        mag_q[0] <= clamp_mag(ax);
        mag_q[1] <= clamp_mag(ay);
        mag_q[2] <= MAG_W'(az);
        sum_q    <= '0;
      end
      ST_SQ: prod_q <= mul_p;
      ST_ACC: begin
        sum_q <= sum_q + prod_q;
        if (idx_q == 2'd2) begin
          work_q <= sum_q + prod_q;
          rem_q  <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        rem_q  <= unit_rem;
        work_q <= {work_q[WORK_W-3:0], 2'b00};
        root_q <= {root_q[ROOT_W-2:0], unit_ge};
      end
      ST_UPD: begin
        if (commit) begin
          out_data_q <= {in_range ? hit_new : '0, in_range ? seen_new : '0,
                         valid_q ? total_new : total_q, dist_val};
          out_user_q <= {hit, valid_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ----- src/jpea_checker.sv -----
module jpea_checker
  import jpea_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  // Hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Drop new input while a joint is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Skipped joint carries no distance and no hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[DIST_W-1:0] == '0 && !m_axis_tuser[1])
    else $error("skipped joint reports distance or hit");

  // Hit implies a valid label
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("hit without valid label");

  // Detected count never exceeds seen count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[135:104] <= m_axis_tdata[103:72])
    else $error("detected count above seen count");

endmodule

bind joint_pose_error_accumulator jpea_checker u_jpea_checker (.*);

// ----- dv/jpea_checker.sv -----
module jpea_scoreboard
  import jpea_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // tdata: joint_index, pred_u, pred_v, pred_depth, label_u, label_v, label_depth
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: clear_totals
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: joint_distance, total_distance, joint_seen, joint_detected
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: joint_valid, joint_hit
  input  logic [OUT_USER_W-1:0] m_axis_tuser,
  output int                    mismatch_count_o,
  output int                    scores_waiting_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [DIST_W-1:0]  distance;
    logic               present;
    logic               hit;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] seen;
    logic [COUNT_W-1:0] detected;
  } joint_score_t;

  // Camera registers as the block should hold them
  logic [FOCAL_W-1:0]  cam_fx, cam_fy;
  logic [CENTER_W-1:0] cam_cx, cam_cy;
  logic [THR_W-1:0]    cam_thr;

  // Running totals as the block should hold them
  logic [COUNT_W-1:0] seen_tally [NUM_JOINTS];
  logic [COUNT_W-1:0] hit_tally  [NUM_JOINTS];
  logic [TOTAL_W-1:0] distance_sum;

  joint_score_t pending_scores [$];
  int           mismatches;

  // Back-project one pixel coordinate: trunc((p - c) * d * 16 / f), zero focal taken as one
  function automatic longint backproject(logic signed [PIX_W-1:0] p, logic [CENTER_W-1:0] c,
                                         logic [DEPTH_W-1:0] d, logic [FOCAL_W-1:0] f);
    longint          diff;
    longint unsigned mag, den, quot;
    diff = longint'(p) - longint'(c);
    mag  = (diff < 0) ? -diff : diff;
    den  = (f == '0) ? 64'd1 : 64'(f);
    quot = (mag * 64'(d) * 64'd16) / den;
    return (diff < 0) ? -longint'(quot) : longint'(quot);
  endfunction

  function automatic longint unsigned clamp_mag(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return (m > 64'(MAG_CLAMP)) ? 64'(MAG_CLAMP) : m;
  endfunction

  // Bit-pair integer square root, floor
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root, probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    -= root + probe;
        root  = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Score one joint and update the running totals
  function automatic joint_score_t score_joint(logic clear, logic [IN_DATA_W-1:0] word);
    logic [JIDX_W-1:0]       idx;
    logic signed [PIX_W-1:0] pu, pv, lu, lv;
    logic [DEPTH_W-1:0]      pd, ld;
    longint                  x1, y1, x2, y2;
    longint unsigned         ax, ay, az, dist_val, acc;
    logic                    in_range, present, hit;
    joint_score_t            s;
    idx = word[4:0];
    pu  = word[20:5];
    pv  = word[36:21];
    pd  = word[54:37];
    lu  = word[70:55];
    lv  = word[86:71];
    ld  = word[104:87];
    in_range = (int'(idx) < NUM_JOINTS);
    if (clear) begin
      foreach (seen_tally[j]) begin
        seen_tally[j] = '0;
        hit_tally[j]  = '0;
      end
      distance_sum = '0;
    end
    present  = (longint'(lu) + longint'(lv) + longint'(ld)) != 0;
    dist_val = 0;
    hit      = 1'b0;
    if (present) begin
      x1   = backproject(pu, cam_cx, pd, cam_fx);
      y1   = backproject(pv, cam_cy, pd, cam_fy);
      x2   = backproject(lu, cam_cx, ld, cam_fx);
      y2   = backproject(lv, cam_cy, ld, cam_fy);
      ax   = clamp_mag(x1 - x2);
      ay   = clamp_mag(y1 - y2);
      az   = clamp_mag(longint'(pd) - longint'(ld));
      dist_val = floor_sqrt(ax * ax + ay * ay + az * az);
      if (dist_val > 64'(DIST_MAX)) dist_val = 64'(DIST_MAX);
      hit  = (dist_val <= 64'(cam_thr));
      acc  = 64'(distance_sum) + dist_val;
      distance_sum = (acc > 64'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];
      if (in_range) begin
        if (seen_tally[idx] != COUNT_MAX) seen_tally[idx] += 1;
        if (hit && hit_tally[idx] != COUNT_MAX) hit_tally[idx] += 1;
      end
    end
    s.distance = dist_val[DIST_W-1:0];
    s.present  = present;
    s.hit      = hit;
    s.total    = distance_sum;
    s.seen     = in_range ? seen_tally[idx] : '0;
    s.detected = in_range ? hit_tally[idx] : '0;
    return s;
  endfunction

  function automatic int field_check(string name, longint unsigned want, longint unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  // Track register writes, queue a score per input transaction, compare each output one
  always @(posedge clk_i or negedge rst_ni) begin : track
    joint_score_t want;
    joint_score_t fresh;
    if (!rst_ni) begin
      cam_fx  = FOCAL_X_RST;
      cam_fy  = FOCAL_Y_RST;
      cam_cx  = CENTER_X_RST;
      cam_cy  = CENTER_Y_RST;
      cam_thr = THR_RST;
      foreach (seen_tally[j]) begin
        seen_tally[j] = '0;
        hit_tally[j]  = '0;
      end
      distance_sum = '0;
      pending_scores.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      scores_waiting_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FOCAL_X:       cam_fx  = cfg_wdata_i[FOCAL_W-1:0];
          REG_FOCAL_Y:       cam_fy  = cfg_wdata_i[FOCAL_W-1:0];
          REG_CENTER_X:      cam_cx  = cfg_wdata_i[CENTER_W-1:0];
          REG_CENTER_Y:      cam_cy  = cfg_wdata_i[CENTER_W-1:0];
          REG_HIT_THRESHOLD: cam_thr = cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fresh = score_joint(s_axis_tuser, s_axis_tdata);
        pending_scores = {pending_scores, fresh};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_scores.size() == 0) begin
          $error("result transaction with no joint outstanding");
          mismatches++;
        end else begin
          want = pending_scores.pop_front();
          mismatches += field_check("joint_distance", want.distance, m_axis_tdata[23:0]);
          mismatches += field_check("joint_valid", want.present, m_axis_tuser[0]);
          mismatches += field_check("joint_hit", want.hit, m_axis_tuser[1]);
          mismatches += field_check("total_distance", want.total, m_axis_tdata[71:24]);
          mismatches += field_check("joint_seen", want.seen, m_axis_tdata[103:72]);
          mismatches += field_check("joint_detected", want.detected, m_axis_tdata[135:104]);
        end
      end
      mismatch_count_o <= mismatches;
      scores_waiting_o <= pending_scores.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jpea_pkg::*;

  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PACKED_W      = JIDX_W + 4 * PIX_W + 2 * DEPTH_W;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  hold_req;
  int                    mismatch_count;
  int                    scores_waiting;

  joint_pose_error_accumulator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  jpea_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatch_count_o (mismatch_count),
    .scores_waiting_o (scores_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int rand_signed(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Offer one joint and hold it until the block takes it
  task automatic offer_joint(input bit clear, input int idx, input int pu, input int pv,
                             input int pd, input int lu, input int lv, input int ld);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[PACKED_W-1:0] = {DEPTH_W'(ld), PIX_W'(lv), PIX_W'(lu), DEPTH_W'(pd),
                          PIX_W'(pv), PIX_W'(pu), JIDX_W'(idx)};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= clear;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Write every camera register plus one unmapped index, noise above each register's width
  task automatic program_camera(input int unsigned fx, input int unsigned fy,
                                input int unsigned cx, input int unsigned cy,
                                input int unsigned thr);
    logic [CFG_IDX_W-1:0] slot  [5];
    int unsigned          width [5];
    int unsigned          value [5];
    slot  = '{REG_FOCAL_X, REG_FOCAL_Y, REG_CENTER_X, REG_CENTER_Y, REG_HIT_THRESHOLD};
    width = '{FOCAL_W, FOCAL_W, CENTER_W, CENTER_W, THR_W};
    value = '{fx, fy, cx, cy, thr};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IDX_W'($urandom_range(REG_HIT_THRESHOLD + 1, 2 ** CFG_IDX_W - 1));
    cfg_wdata_i <= CFG_W'($urandom);
    @(posedge clk_i);
    for (int r = 0; r < 5; r++) begin
      cfg_index_i <= slot[r];
      cfg_wdata_i <= (CFG_W'($urandom) << width[r]) | CFG_W'(value[r]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering and wait until every queued score has been matched
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (scores_waiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One random joint: mostly close prediction/label pairs, some skipped labels, some noise
  task automatic random_joint();
    int kind, span, idx, pu, pv, pd, lu, lv, ld;
    bit clear;
    kind  = $urandom_range(0, 99);
    clear = ($urandom_range(0, 39) == 0);
    idx   = $urandom_range(0, NUM_JOINTS - 1);
    pu    = int'($urandom_range(0, 65535)) - 32768;
    pv    = int'($urandom_range(0, 65535)) - 32768;
    pd    = $urandom_range(0, 262143);
    lu    = int'($urandom_range(0, 65535)) - 32768;
    lv    = int'($urandom_range(0, 65535)) - 32768;
    ld    = $urandom_range(0, 262143);
    if (kind < 15) begin
      // label fields that cancel out
      ld = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 32767);
      lu = -int'($urandom_range(0, 32767));
      lv = -(lu + ld);
    end else if (kind >= 40) begin
      ld   = ($urandom_range(0, 3) == 0) ? ld : $urandom_range(200, 20000);
      case ($urandom_range(0, 3))
        0:       span = 0;
        1:       span = 4;
        2:       span = 64;
        default: span = 1024;
      endcase
      pu = clip(lu + rand_signed(span), -32768, 32767);
      pv = clip(lv + rand_signed(span), -32768, 32767);
      pd = clip(ld + rand_signed(span * 8), 0, 262143);
    end
    offer_joint(clear, idx, pu, pv, pd, lu, lv, ld);
  endtask

  // Send joints in bursts separated by random gaps
  task automatic run_batch(input int count);
    int burst, gap;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 260);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 12);
      end
      random_joint();
      burst--;
    end
  endtask

  // Output side: one long hold-off on request, otherwise a changing stall pattern
  initial begin : receiver
    rx_mode_e mode;
    int       slot_left, hold_left;
    bit       hold_done;
    m_axis_tready = 1'b0;
    mode      = RX_OPEN;
    slot_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        if (slot_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          slot_left = $urandom_range(16, 400);
        end
        slot_left--;
        case (mode)
          RX_OPEN: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("joint_pose_error_accumulator: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_FOCAL_X;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    hold_req      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset camera: exact hits, threshold edge, field extremes, skipped labels, clears
    offer_joint(1, 0, 5120, 3840, 1000, 5120, 3840, 1000);
    offer_joint(0, 0, 5120, 3840, 1000, 5120, 3840, 1320);
    offer_joint(0, 0, 5120, 3840, 1000, 5120, 3840, 1321);
    offer_joint(0, 31, -32768, 32767, 262143, 32767, -32768, 0);
    offer_joint(0, 31, 32767, -32768, 0, -32768, 32767, 262143);
    offer_joint(0, 5, 1234, -999, 4000, 0, 0, 0);
    offer_joint(0, 5, 300, 200, 100, -32768, 32767, 1);
    offer_joint(0, 5, 4000, 3000, 20000, 4010, 2990, 20010);
    offer_joint(0, 31, -32768, 32767, 262143, 32767, -32768, 0);
    offer_joint(1, 31, 0, 0, 0, 100, -300, 200);
    offer_joint(0, 0, -200, -4000, 8000, -190, -4005, 8003);
    offer_joint(0, 16, 32767, 32767, 262143, 32767, 32767, 262143);
    offer_joint(0, 1, 0, 0, 0, 0, 0, 1);
    offer_joint(0, 1, -32768, -32768, 0, -32768, -32767, 5);
    offer_joint(0, 1, 7000, 5000, 3000, 6990, 5012, 2998);
    drain();

    // Zero focal lengths, threshold at its top: distances saturate
    program_camera(0, 0, 0, 2 ** CENTER_W - 1, 2 ** THR_W - 1);
    offer_joint(0, 2, -32768, 32767, 262143, 32767, -32768, 0);
    offer_joint(0, 2, 1, -1, 1, 0, 0, 1);
    run_batch(100);
    drain();

    // Widest focal lengths, threshold zero: only zero distances hit
    program_camera(2 ** FOCAL_W - 1, 2 ** FOCAL_W - 1, 2 ** CENTER_W - 1, 0, 0);
    offer_joint(0, 3, 100, 100, 5000, 100, 100, 5000);
    offer_joint(0, 3, 100, 100, 5000, 100, 100, 5001);
    run_batch(100);
    drain();

    // Random cameras, with one long output hold-off
    for (int phase = 0; phase < 5; phase++) begin
      program_camera(($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 ** FOCAL_W - 1)
                                                 : $urandom_range(100000, 200000),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 ** FOCAL_W - 1)
                                                 : $urandom_range(100000, 200000),
                     $urandom_range(0, 2 ** CENTER_W - 1),
                     $urandom_range(0, 2 ** CENTER_W - 1),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 ** THR_W - 1)
                                                 : $urandom_range(0, 4000));
      if (phase == 1) hold_req <= 1'b1;
      run_batch(130);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("joint_pose_error_accumulator: match");
    end else begin
      $display("joint_pose_error_accumulator: mismatch");
    end
    $finish;
  end

endmodule
